// ===== rtl/dfl_pkg.sv =====
// Shared types and constants of the delta-pressure flow linearizer.
// Sequencer states, register indexes, branch codes and the control structs
// between the top level and the core. Depends on nothing.
`timescale 1ns / 1ps

package dfl_pkg;

    // Sequencer states of the core
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQRT,
        ST_MUL,
        ST_FIN,
        ST_DONE
    } t_state;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FLOW_MODE = 3'd0,
        CFG_MODE_BAD  = 3'd1,
        CFG_GAIN_SQRT = 3'd2,
        CFG_GAIN_LIN  = 3'd3,
        CFG_OFFSET    = 3'd4,
        CFG_ALPHA     = 3'd5
    } t_cfg_idx;

    // Branch codes reported with each result
    localparam logic [1:0] BR_PASS = 2'd0;
    localparam logic [1:0] BR_SQRT = 2'd1;
    localparam logic [1:0] BR_LIN  = 2'd2;
    localparam logic [1:0] BR_HELD = 2'd3;

    // Top level to core
    typedef struct packed {
        logic start;
        logic take;
    } t_core_ctl;

    // Core to top level
    typedef struct packed {
        logic idle;
        logic done;
    } t_core_sts;

endpackage

// ===== rtl/dfl_alu.sv =====
// Shared adder/subtractor of the flow linearizer core.
// Serves square-root trial subtraction, shift-add multiply and the offset add.
// Depends on nothing.
`timescale 1ns / 1ps

module dfl_alu #(
    parameter int WIDTH = 34
) (
    input  logic [WIDTH-1:0] i_a,
    input  logic [WIDTH-1:0] i_b,
    input  logic             i_sub,
    output logic [WIDTH-1:0] o_sum,
    output logic             o_carry
);

    // carry out set on subtract means a >= b
    assign {o_carry, o_sum} = {1'b0, i_a} + {1'b0, i_b ^ {WIDTH{i_sub}}}
                            + (WIDTH + 1)'(i_sub);

endmodule

// ===== rtl/dfl_core.sv =====
// Sequencer and datapath registers of the flow linearizer.
// Runs digit-by-digit square root, shift-add multiply and final saturation
// on one shared dfl_alu. Depends on dfl_pkg and dfl_alu.
`timescale 1ns / 1ps

module dfl_core
    import dfl_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_core_ctl                    i_ctl,
    output t_core_sts                    o_sts,
    input  logic signed [DATA_WIDTH-1:0] i_sample,
    input  logic                         i_flow_mode,
    input  logic                         i_mode_bad,
    input  logic        [DATA_WIDTH-1:0] i_gain_sqrt,
    input  logic signed [DATA_WIDTH-1:0] i_gain_linear,
    input  logic signed [DATA_WIDTH-1:0] i_flow_offset,
    input  logic signed [DATA_WIDTH-1:0] i_alpha,
    output logic        [DATA_WIDTH-1:0] o_res,
    output logic                         o_health,
    output logic        [1:0]            o_branch,
    output logic                         o_sat
);

    localparam int W      = DATA_WIDTH;
    localparam int F      = FRAC_BITS;
    localparam int ROOT_W = (W + F) / 2;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 1;
    localparam int QW_A   = (ROOT_W > W) ? ROOT_W : W;
    localparam int QW     = (QW_A > F + 1) ? QW_A : F + 1;
    localparam int PROD_W = W + QW;
    localparam int UW     = (ROOT_W > W) ? ROOT_W + 2 : W + 2;
    localparam int CNT_W  = $clog2(QW);

    localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [RAD_W-1:0]    r_rad, n_rad;
    logic [REM_W-1:0]    r_rem, n_rem;
    logic [ROOT_W-1:0]   r_root, n_root;
    logic [W-1:0]        r_mcand, n_mcand;
    logic [PROD_W-1:0]   r_prod, n_prod;
    logic                r_neg, n_neg;
    logic [W-1:0]        r_held, n_held;
    logic [W-1:0]        r_res, n_res;
    logic                r_health, n_health;
    logic [1:0]          r_branch, n_branch;
    logic                r_sat, n_sat;

    logic [UW-1:0]       alu_a, alu_b, alu_sum;
    logic                alu_sub, alu_carry;

    logic [ROOT_W+1:0]   rem_sh;
    logic [ROOT_W+1:0]   trial;
    logic [W-2:0]        x_mag;
    logic [W-1:0]        g_mag, s_mag;
    logic [W:0]          mul_t;
    logic                fits;

    dfl_alu #(.WIDTH(UW)) u_alu (
        .i_a     (alu_a),
        .i_b     (alu_b),
        .i_sub   (alu_sub),
        .o_sum   (alu_sum),
        .o_carry (alu_carry)
    );

    assign rem_sh = {r_rem[ROOT_W-1:0], r_rad[RAD_W-1 -: 2]};
    assign trial  = {r_root, 2'b01};
    assign x_mag  = i_sample[W-1] ? '0 : i_sample[W-2:0];
    assign g_mag  = i_gain_linear[W-1] ? W'(-i_gain_linear) : W'(i_gain_linear);
    assign s_mag  = i_sample[W-1] ? W'(-i_sample) : W'(i_sample);
    assign mul_t  = alu_sum[W:0];
    assign fits   = (&alu_sum[UW-1:W-1]) || !(|alu_sum[UW-1:W-1]);

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_rad    = r_rad;
        n_rem    = r_rem;
        n_root   = r_root;
        n_mcand  = r_mcand;
        n_prod   = r_prod;
        n_neg    = r_neg;
        n_held   = r_held;
        n_res    = r_res;
        n_health = r_health;
        n_branch = r_branch;
        n_sat    = r_sat;
        alu_a    = '0;
        alu_b    = '0;
        alu_sub  = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_ctl.start) begin
                    n_health = 1'b1;
                    n_sat    = 1'b0;
                    if (i_mode_bad) begin
                        n_res    = r_held;
                        n_health = 1'b0;
                        n_branch = BR_HELD;
                        n_state  = ST_DONE;
                    end else if (!i_flow_mode) begin
                        n_res    = i_sample;
                        n_held   = i_sample;
                        n_branch = BR_PASS;
                        n_state  = ST_DONE;
                    end else if (i_alpha > i_sample) begin
                        // negative radicand: clamp to zero and flag
                        n_sat    = i_sample[W-1];
                        n_rad    = RAD_W'(x_mag) << F;
                        n_rem    = '0;
                        n_root   = '0;
                        n_branch = BR_SQRT;
                        n_cnt    = CNT_W'(ROOT_W - 1);
                        n_state  = ST_SQRT;
                    end else begin
                        n_neg    = i_gain_linear[W-1] ^ i_sample[W-1];
                        n_mcand  = g_mag;
                        n_prod   = PROD_W'(s_mag);
                        n_branch = BR_LIN;
                        n_cnt    = CNT_W'(QW - 1);
                        n_state  = ST_MUL;
                    end
                end
            end
            ST_SQRT: begin
                // one root bit a cycle
                alu_a   = UW'(rem_sh);
                alu_b   = UW'(trial);
                alu_sub = 1'b1;
                n_rad   = r_rad << 2;
                if (alu_carry) begin
                    n_rem  = alu_sum[REM_W-1:0];
                    n_root = {r_root[ROOT_W-2:0], 1'b1};
                end else begin
                    n_rem  = rem_sh[REM_W-1:0];
                    n_root = {r_root[ROOT_W-2:0], 1'b0};
                end
                if (r_cnt == '0) begin
                    n_mcand = i_gain_sqrt;
                    n_prod  = PROD_W'(n_root);
                    n_cnt   = CNT_W'(QW - 1);
                    n_state = ST_MUL;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_MUL: begin
                // one multiplier bit a cycle, product shifts right
                alu_a  = UW'(r_prod[PROD_W-1 -: W]);
                alu_b  = r_prod[0] ? UW'(r_mcand) : '0;
                n_prod = {mul_t, r_prod[QW-1:1]};
                if (r_cnt == '0) begin
                    n_state = ST_FIN;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_FIN: begin
                alu_a   = {{(UW-W){i_flow_offset[W-1]}}, i_flow_offset};
                alu_b   = UW'(r_prod[W+F-1:F]);
                alu_sub = r_neg;
                case (r_branch)
                    BR_SQRT: begin
                        if (|r_prod[PROD_W-1:W+F-1]) begin
                            n_res = SMAX;
                            n_sat = 1'b1;
                        end else begin
                            n_res = {1'b0, r_prod[W+F-2:F]};
                        end
                    end
                    default: begin
                        if (|r_prod[PROD_W-1:W+F]) begin
                            n_res = r_neg ? SMIN : SMAX;
                            n_sat = 1'b1;
                        end else if (!fits) begin
                            n_res = alu_sum[UW-1] ? SMIN : SMAX;
                            n_sat = 1'b1;
                        end else begin
                            n_res = alu_sum[W-1:0];
                        end
                    end
                endcase
                n_held  = n_res;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_ctl.take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_held  <= '0;
        end else begin
            r_state <= n_state;
            r_held  <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt    <= n_cnt;
        r_rad    <= n_rad;
        r_rem    <= n_rem;
        r_root   <= n_root;
        r_mcand  <= n_mcand;
        r_prod   <= n_prod;
        r_neg    <= n_neg;
        r_res    <= n_res;
        r_health <= n_health;
        r_branch <= n_branch;
        r_sat    <= n_sat;
    end

    assign o_sts.idle = (r_state == ST_IDLE);
    assign o_sts.done = (r_state == ST_DONE);
    assign o_res      = r_res;
    assign o_health   = r_health;
    assign o_branch   = r_branch;
    assign o_sat      = r_sat;

endmodule

// ===== rtl/deltap_flow_linearizer.sv =====
// Top level of the delta-pressure flow linearizer.
// Holds the configuration registers and the output register around dfl_core.
// Depends on dfl_pkg and dfl_core.
`timescale 1ns / 1ps

// Usage
//   Input channel: i_pressure_sample with i_in_valid / o_in_stall. A word is
//   taken on a rising edge with valid high and stall low.
//   Output channel: flow value, health, branch and saturation flag with
//   o_out_valid / i_out_stall; the word holds steady while stalled.
//   Configuration: i_cfg_index / i_cfg_data with i_cfg_valid / o_cfg_ready;
//   ready is always high, write only while no word is in flight.
// Sequence
//   Mode bad or pass-through: the result is set when the word is taken.
//   Linear branch: shift-add multiply by the linear gain, then offset add and saturation.
//   Square-root branch: digit-by-digit root, multiply by the square-root gain, then saturation.
//   The core takes one word at a time; its single shared adder does one root
//   bit or one multiplier bit each cycle. The next word is accepted as soon
//   as the result moves into the output register, even if it waits there.
// Reset (synchronous, i_rst_n low) clears the configuration registers, the
// held flow value, the core state and the output valid; data registers are
// simply overwritten. A stalled receiver holds the output register; the
// core then waits with its result and holds o_in_stall high.
module deltap_flow_linearizer
    import dfl_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic signed [DATA_WIDTH-1:0] i_pressure_sample,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [DATA_WIDTH-1:0] o_flow_value,
    output logic                         o_health_good,
    output logic        [1:0]            o_branch_used,
    output logic                         o_saturated,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic        [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic        [DATA_WIDTH-1:0] i_cfg_data
);

    logic                         r_flow_mode;
    logic                         r_mode_bad;
    logic        [DATA_WIDTH-1:0] r_gain_sqrt;
    logic signed [DATA_WIDTH-1:0] r_gain_linear;
    logic signed [DATA_WIDTH-1:0] r_flow_offset;
    logic signed [DATA_WIDTH-1:0] r_alpha;

    logic                         r_out_valid;
    logic        [DATA_WIDTH-1:0] r_out_flow;
    logic                         r_out_health;
    logic        [1:0]            r_out_branch;
    logic                         r_out_sat;

    t_core_ctl                    core_ctl;
    t_core_sts                    core_sts;
    logic        [DATA_WIDTH-1:0] core_res;
    logic                         core_health;
    logic        [1:0]            core_branch;
    logic                         core_sat;
    logic                         out_load;

    // Configuration writes: unknown indexes are dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flow_mode   <= 1'b0;
            r_mode_bad    <= 1'b0;
            r_gain_sqrt   <= '0;
            r_gain_linear <= '0;
            r_flow_offset <= '0;
            r_alpha       <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_FLOW_MODE: r_flow_mode   <= i_cfg_data[0];
                CFG_MODE_BAD:  r_mode_bad    <= i_cfg_data[0];
                CFG_GAIN_SQRT: r_gain_sqrt   <= i_cfg_data;
                CFG_GAIN_LIN:  r_gain_linear <= i_cfg_data;
                CFG_OFFSET:    r_flow_offset <= i_cfg_data;
                CFG_ALPHA:     r_alpha       <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Accept a word only while the core is idle
    assign o_in_stall     = !core_sts.idle;
    assign core_ctl.start = i_in_valid && core_sts.idle;

    // Advance the finished result when the output register is free or emptying
    assign out_load      = core_sts.done && (!r_out_valid || !i_out_stall);
    assign core_ctl.take = out_load;

    dfl_core #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (core_ctl),
        .o_sts         (core_sts),
        .i_sample      (i_pressure_sample),
        .i_flow_mode   (r_flow_mode),
        .i_mode_bad    (r_mode_bad),
        .i_gain_sqrt   (r_gain_sqrt),
        .i_gain_linear (r_gain_linear),
        .i_flow_offset (r_flow_offset),
        .i_alpha       (r_alpha),
        .o_res         (core_res),
        .o_health      (core_health),
        .o_branch      (core_branch),
        .o_sat         (core_sat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_flow   <= core_res;
            r_out_health <= core_health;
            r_out_branch <= core_branch;
            r_out_sat    <= core_sat;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_flow_value  = r_out_flow;
    assign o_health_good = r_out_health;
    assign o_branch_used = r_out_branch;
    assign o_saturated   = r_out_sat;

endmodule

// ===== rtl/dfl_chk.sv =====
// Port-level checker for the flow linearizer, bound to the top level.
// Watches handshake and result coherence. Depends on dfl_pkg.
`timescale 1ns / 1ps

module dfl_chk
    import dfl_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input logic [DATA_WIDTH-1:0] o_flow_value,
    input logic                  o_health_good,
    input logic [1:0]            o_branch_used,
    input logic                  o_saturated
);

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_flow_value)
            && $stable(o_branch_used) && $stable(o_saturated)))
        else $error("stalled result word changed");

    // Health is bad exactly when the held value is repeated
    a_health: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_health_good == (o_branch_used != BR_HELD)))
        else $error("health and branch disagree");

    // Pass-through and held words never carry the saturation flag
    a_no_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_branch_used == BR_PASS || o_branch_used == BR_HELD))
            |-> !o_saturated)
        else $error("saturation flag on pass-through or held word");

    // One word at a time: stall right after an accepted word
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second word taken while busy");

endmodule

bind deltap_flow_linearizer dfl_chk #(.DATA_WIDTH(DATA_WIDTH)) u_dfl_chk (.*);

// ===== tb/dfl_flow_checker.sv =====
// Checker of the delta-pressure flow linearizer: watches the input, output
// and configuration channels, predicts each result word and compares it.
// Depends on dfl_pkg for the register indexes and branch codes.
`timescale 1ns / 1ps

module dfl_flow_checker
    import dfl_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic signed [31:0]          i_pressure_sample,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic signed [31:0]          i_flow_value,
    input  logic                        i_health_good,
    input  logic        [1:0]           i_branch_used,
    input  logic                        i_saturated,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_ready,
    input  logic        [CFG_IDX_W-1:0] i_cfg_index,
    input  logic        [31:0]          i_cfg_data,
    output int                          o_mismatches,
    output int                          o_outstanding
);

    localparam longint FLOW_MAX = 64'sd2147483647;
    localparam longint FLOW_MIN = -64'sd2147483648;

    typedef struct packed {
        logic signed [31:0] flow;
        logic               health;
        logic        [1:0]  branch;
        logic               sat;
    } t_flow_word;

    t_flow_word pending_flows[$];

    logic               flow_mode_q;
    logic               mode_bad_q;
    logic        [31:0] gain_sqrt_q;
    logic signed [31:0] gain_lin_q;
    logic signed [31:0] offset_q;
    logic signed [31:0] alpha_q;
    logic signed [31:0] held_flow;

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        o_mismatches++;
        $display("%0t flow check: %s got %h, expected %h", $time, field, got, want);
    endtask

    // floor(sqrt(mag << 16)), one root bit per step
    function automatic logic [31:0] scaled_root(input logic [31:0] mag);
        logic [63:0] radicand;
        logic [63:0] root;
        logic [63:0] trial;
        radicand = {16'h0, mag, 16'h0};
        root = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= radicand) root = trial;
        end
        return root[31:0];
    endfunction

    function automatic t_flow_word predict_flow(input logic signed [31:0] sample);
        t_flow_word         w;
        logic        [31:0] mag_s;
        logic        [31:0] mag_g;
        logic        [63:0] prod;
        logic signed [63:0] sum;
        logic               neg;
        w.health = 1'b1;
        w.sat = 1'b0;
        if (mode_bad_q) begin
            // hold the last good value, leave it untouched
            w.flow = held_flow;
            w.health = 1'b0;
            w.branch = BR_HELD;
            return w;
        end
        if (!flow_mode_q) begin
            w.flow = sample;
            w.branch = BR_PASS;
        end else if (alpha_q > sample) begin
            w.branch = BR_SQRT;
            // clamp a negative radicand to zero and flag it
            mag_s = sample[31] ? 32'd0 : sample;
            w.sat = sample[31];
            prod = ({32'd0, gain_sqrt_q} * {32'd0, scaled_root(mag_s)}) >> 16;
            if (prod > 64'h7FFF_FFFF) begin
                w.flow = 32'h7FFF_FFFF;
                w.sat = 1'b1;
            end else begin
                w.flow = prod[31:0];
            end
        end else begin
            w.branch = BR_LIN;
            neg = gain_lin_q[31] ^ sample[31];
            mag_g = gain_lin_q[31] ? -gain_lin_q : gain_lin_q;
            mag_s = sample[31] ? -sample : sample;
            prod = ({32'd0, mag_g} * {32'd0, mag_s}) >> 16;
            if (prod >= 64'h1_0000_0000) begin
                w.flow = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
                w.sat = 1'b1;
            end else begin
                sum = $signed(prod);
                if (neg) sum = -sum;
                sum = sum + offset_q;
                if (sum > FLOW_MAX) begin
                    w.flow = 32'h7FFF_FFFF;
                    w.sat = 1'b1;
                end else if (sum < FLOW_MIN) begin
                    w.flow = 32'h8000_0000;
                    w.sat = 1'b1;
                end else begin
                    w.flow = sum[31:0];
                end
            end
        end
        held_flow = w.flow;
        return w;
    endfunction

    always @(posedge i_clk) begin
        t_flow_word want;
        if (!i_rst_n) begin
            pending_flows.delete();
            flow_mode_q = 1'b0;
            mode_bad_q = 1'b0;
            gain_sqrt_q = '0;
            gain_lin_q = '0;
            offset_q = '0;
            alpha_q = '0;
            held_flow = '0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_FLOW_MODE: flow_mode_q = i_cfg_data[0];
                    CFG_MODE_BAD:  mode_bad_q = i_cfg_data[0];
                    CFG_GAIN_SQRT: gain_sqrt_q = i_cfg_data;
                    CFG_GAIN_LIN:  gain_lin_q = i_cfg_data;
                    CFG_OFFSET:    offset_q = i_cfg_data;
                    CFG_ALPHA:     alpha_q = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (pending_flows.size() == 0) begin
                    report_mismatch("word with none expected", i_flow_value, '0);
                end else begin
                    want = pending_flows.pop_front();
                    if (i_flow_value !== want.flow)
                        report_mismatch("flow_value", i_flow_value, want.flow);
                    if (i_health_good !== want.health)
                        report_mismatch("health_good", 32'(i_health_good),
                                        32'(want.health));
                    if (i_branch_used !== want.branch)
                        report_mismatch("branch_used", 32'(i_branch_used),
                                        32'(want.branch));
                    if (i_saturated !== want.sat)
                        report_mismatch("saturated", 32'(i_saturated), 32'(want.sat));
                end
            end
            if (i_in_valid && !i_in_stall)
                pending_flows.push_back(predict_flow(i_pressure_sample));
        end
        o_outstanding = pending_flows.size();
    end

endmodule

// ===== tb/deltap_flow_linearizer_tb.sv =====
// Top of the flow linearizer testbench: clock, reset, stimulus and verdict.
// Depends on dfl_pkg, deltap_flow_linearizer and dfl_flow_checker.
`timescale 1ns / 1ps

module deltap_flow_linearizer_tb;
    import dfl_pkg::*;

    // Indexes beyond the register list; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    // Cycles without any handshake before the run is declared hung. The
    // slowest word (square root) plus the longest receiver stall and sender
    // gap stays well below a tenth of this.
    localparam int QUIET_LIMIT = 4000;
    localparam int RANDOM_WORDS = 1150;
    localparam int TAIL_CYCLES = 64;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic signed [31:0]     pressure;
    logic                   out_valid;
    logic                   out_stall;
    logic signed [31:0]     flow_value;
    logic                   health_good;
    logic [1:0]             branch_used;
    logic                   saturated;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [31:0]            cfg_data;
    int                     mismatches;
    int                     outstanding;

    logic [31:0]            alpha_now;
    int                     burst_left;
    int                     random_sent;

    deltap_flow_linearizer dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_pressure_sample (pressure),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_flow_value      (flow_value),
        .o_health_good     (health_good),
        .o_branch_used     (branch_used),
        .o_saturated       (saturated),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data)
    );

    dfl_flow_checker u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_stall        (in_stall),
        .i_pressure_sample (pressure),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_flow_value      (flow_value),
        .i_health_good     (health_good),
        .i_branch_used     (branch_used),
        .i_saturated       (saturated),
        .i_cfg_valid       (cfg_valid),
        .i_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .o_mismatches      (mismatches),
        .o_outstanding     (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one sample word and hold it until the block takes it. Words go
    // out in bursts of random length; before each burst insert a random gap
    // (sometimes none) with valid low.
    task automatic send_sample(input logic [31:0] sample);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge clk);
                in_valid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        in_valid = 1'b1;
        pressure = sample;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        burst_left--;
    endtask

    // Drop valid and wait until every predicted word has come out
    task automatic drain_words();
        @(negedge clk);
        in_valid = 1'b0;
        burst_left = 0;
        while (outstanding != 0) @(negedge clk);
    endtask

    // Valid is left high between back-to-back writes; load_settings drops it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    // One-bit registers get random upper bits; only bit 0 counts
    function automatic logic [31:0] padded_flag(input logic flag);
        logic [31:0] w;
        w = $urandom;
        w[0] = flag;
        return w;
    endfunction

    task automatic load_settings(input logic mode, input logic bad,
                                 input logic [31:0] g_sqrt, input logic [31:0] g_lin,
                                 input logic [31:0] offset, input logic [31:0] alpha);
        write_reg(CFG_FLOW_MODE, padded_flag(mode));
        write_reg(CFG_MODE_BAD, padded_flag(bad));
        write_reg(CFG_GAIN_SQRT, g_sqrt);
        write_reg(CFG_GAIN_LIN, g_lin);
        write_reg(CFG_OFFSET, offset);
        write_reg(CFG_ALPHA, alpha);
        @(negedge clk);
        cfg_valid = 1'b0;
        alpha_now = alpha;
    endtask

    // Lean towards the range limits and small magnitudes
    function automatic logic [31:0] biased_word();
        logic [31:0] w;
        case ($urandom_range(0, 7))
            0: w = 32'h0000_0000;
            1: w = 32'hFFFF_FFFF;
            2: w = 32'h7FFF_FFFF;
            3: w = 32'h8000_0000;
            4: w = $urandom_range(0, 32'h0004_0000);
            5: w = 32'd0 - $urandom_range(1, 32'h0004_0000);
            default: w = $urandom;
        endcase
        return w;
    endfunction

    // Many samples land near the threshold so both branches are hit
    function automatic logic [31:0] pick_sample(input logic [31:0] alpha);
        logic [31:0] w;
        case ($urandom_range(0, 7))
            0: w = alpha + $urandom_range(0, 512) - 32'd256;
            1: w = alpha;
            2: w = biased_word();
            3: w = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            default: w = $urandom;
        endcase
        return w;
    endfunction

    // Receiver: hold each stall regime for a random stretch, then pick anew -
    // never stall, light random, heavy random, and long alternating stretches
    initial begin : receiver
        int regime;
        int regime_left;
        int hold;
        out_stall = 1'b0;
        regime = 0;
        regime_left = 0;
        hold = 0;
        forever begin
            @(negedge clk);
            if (regime_left == 0) begin
                regime = $urandom_range(0, 3);
                regime_left = $urandom_range(50, 400);
            end
            regime_left--;
            case (regime)
                0: out_stall = 1'b0;
                1: out_stall = ($urandom_range(0, 3) == 0);
                2: out_stall = ($urandom_range(0, 3) != 0);
                default: begin
                    if (hold == 0) begin
                        out_stall = ~out_stall;
                        hold = $urandom_range(1, 40);
                    end
                    hold--;
                end
            endcase
        end
    end

    // Watchdog: end the run once no word has moved on any channel for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("deltap_flow_linearizer: mismatch");
        $finish;
    end

    initial begin : stimulus
        int words;
        logic mode;
        logic bad;
        rst_n = 1'b0;
        in_valid = 1'b0;
        pressure = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        alpha_now = '0;
        burst_left = 0;
        random_sent = 0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // Registers at their reset values: plain pass-through, sign extremes
        send_sample(32'h0000_0000);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h8000_0000);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'h0001_0000);
        drain_words();

        // Writes to indexes past the register list must change nothing
        write_reg(CFG_SPARE_LO, $urandom);
        write_reg(CFG_SPARE_HI, $urandom);
        @(negedge clk);
        cfg_valid = 1'b0;
        send_sample(32'h1234_5678);
        drain_words();

        // Largest gains: root overflow, negative radicand, linear overflow;
        // finish on a saturated linear word so the held value is the top bound
        load_settings(1'b1, 1'b0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      32'h7FFF_FFFF);
        send_sample(32'h7FFF_FFFE);
        send_sample(32'hFFFF_FFFB);
        send_sample(32'h0001_0000);
        send_sample(32'h0000_0000);
        send_sample(32'h7FFF_FFFF);
        drain_words();

        // Mode bad: repeat the held value whatever comes in
        load_settings(1'b1, 1'b1, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0);
        send_sample(32'h1234_5678);
        send_sample(32'h8000_0000);
        drain_words();

        // Most negative slope, offset and threshold: everything linear
        load_settings(1'b1, 1'b0, 32'h0001_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h8000_0000);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h8000_0000);
        send_sample(32'h0000_0000);
        send_sample(32'hFFFF_FFFF);
        drain_words();

        // Unit slope with a large offset: clip on the sum alone, then a negative radicand
        load_settings(1'b1, 1'b0, 32'h0001_0000, 32'h0001_0000, 32'h7FFF_0000,
                      32'h0000_0000);
        send_sample(32'h0002_0000);
        send_sample(32'hFFFF_0000);
        drain_words();

        // Negative unit slope onto the lowest offset: clip below, then exact
        load_settings(1'b1, 1'b0, 32'h0001_0000, 32'hFFFF_0000, 32'h8000_0000,
                      32'h8000_0000);
        send_sample(32'h0001_0000);
        send_sample(32'h0000_0000);
        drain_words();

        // Plain square roots with unit gain
        load_settings(1'b1, 1'b0, 32'h0001_0000, 32'h0, 32'h0, 32'h7FFF_FFFF);
        send_sample(32'h0004_0000);
        send_sample(32'h0002_0000);
        send_sample(32'h0000_0001);
        drain_words();

        // Random phases: fresh settings, then a run of samples around them
        while (random_sent < RANDOM_WORDS) begin
            mode = ($urandom_range(0, 5) != 0);
            bad = ($urandom_range(0, 7) == 0);
            load_settings(mode, bad, biased_word(), biased_word(), biased_word(),
                          biased_word());
            words = $urandom_range(10, 70);
            repeat (words) begin
                send_sample(pick_sample(alpha_now));
                random_sent++;
            end
            drain_words();
        end

        // Let any stray word surface before the verdict
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("deltap_flow_linearizer: match");
        else
            $display("deltap_flow_linearizer: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/dfl_pkg.sv
rtl/dfl_alu.sv
rtl/dfl_core.sv
rtl/deltap_flow_linearizer.sv
rtl/dfl_chk.sv
tb/dfl_flow_checker.sv
tb/deltap_flow_linearizer_tb.sv
